FILE: rtl/mandelbrot_escape_counter_top_assert.svh
// Assertion macros used by the escape counter checker.
`ifndef MANDELBROT_ESCAPE_COUNTER_TOP_ASSERT_SVH
`define MANDELBROT_ESCAPE_COUNTER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MEC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MEC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/mec_pkg.sv
// Shared types and constants of the Mandelbrot escape counter.
`default_nettype none

package mec_pkg;

  localparam int COORD_W = 32;
  localparam int COUNT_W = 9;

  typedef struct packed {
    logic signed [COORD_W-1:0] c_real;
    logic signed [COORD_W-1:0] c_imag;
  } point_t;

  typedef struct packed {
    logic [COUNT_W-1:0] escape_count;
  } count_t;

endpackage

`default_nettype wire

FILE: rtl/mec_stream_if.sv
// Valid/ready stream interface carrying one payload of type T per transaction.
`default_nettype none

interface mec_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/mandelbrot_escape_counter_top.sv
// One iteration z = z^2 + c takes one pass through a three-stage loop (mult, diff, add/sat).
// Up to three points circulate at once; points enter in consecutive cycles while loop slots
// are free and the output register is not stalled.
// Reset (rst, synchronous) empties the loop and the output register.
`default_nettype none

module mandelbrot_escape_counter_top
  import mec_pkg::*;
#(
  parameter int MAX_STEPS = 256,
  parameter int FRAC_BITS = 28
) (
  input  logic          clk,
  input  logic          rst,
  mec_stream_if.sink    point,
  mec_stream_if.source  result
);

  localparam int K_W    = $clog2(MAX_STEPS + 1);
  localparam int PROD_W = 2 * COORD_W;
  localparam int SUM_W  = PROD_W + 1;

  localparam logic [PROD_W-1:0]        ESC_LIMIT = PROD_W'(4) << FRAC_BITS;
  localparam logic signed [SUM_W-1:0]  POS_LIM   = SUM_W'({1'b0, {(COORD_W-1){1'b1}}});
  localparam logic signed [SUM_W-1:0]  NEG_LIM   = ~POS_LIM;
  localparam logic [K_W-1:0]           LAST_K    = K_W'(MAX_STEPS - 1);

  typedef struct packed {
    logic signed [COORD_W-1:0] cr;
    logic signed [COORD_W-1:0] ci;
    logic [K_W-1:0]            k;
    logic [K_W-1:0]            cnt;
    logic                      done;
  } ctx_t;

  function automatic logic signed [COORD_W-1:0] sat(input logic signed [SUM_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > POS_LIM) begin
      r = POS_LIM[COORD_W-1:0];
    end else if (v < NEG_LIM) begin
      r = NEG_LIM[COORD_W-1:0];
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

  // Loop head: current iterate.
  logic                      p0_valid;
  ctx_t                      p0_ctx;
  logic signed [COORD_W-1:0] p0_zr;
  logic signed [COORD_W-1:0] p0_zi;

  // Products.
  logic                      p1_valid;
  ctx_t                      p1_ctx;
  logic signed [PROD_W-1:0]  p1_rr;
  logic signed [PROD_W-1:0]  p1_ii;
  logic signed [PROD_W-1:0]  p1_ri;

  // Difference of squares and escape test.
  logic                      p2_valid;
  ctx_t                      p2_ctx;
  logic signed [PROD_W-1:0]  p2_diff;
  logic signed [PROD_W-1:0]  p2_ri;
  logic                      p2_esc;

  logic                      res_valid;
  logic [COUNT_W-1:0]        res_count;

  logic [PROD_W-1:0]         sq_sum;
  logic signed [PROD_W-1:0]  re_shift;
  logic signed [PROD_W-1:0]  im_shift;
  logic signed [SUM_W-1:0]   re_full;
  logic signed [SUM_W-1:0]   im_full;
  logic                      p2_last;
  logic                      esc_now;
  ctx_t                      loop_ctx;
  logic                      recirc;
  logic                      stall;
  logic                      take;
  logic                      res_load;

  assign sq_sum = $unsigned(p1_rr) + $unsigned(p1_ii);

  assign re_shift = p2_diff >>> FRAC_BITS;
  assign im_shift = p2_ri >>> (FRAC_BITS - 1);
  assign re_full  = SUM_W'(re_shift) + SUM_W'(p2_ctx.cr);
  assign im_full  = SUM_W'(im_shift) + SUM_W'(p2_ctx.ci);

  assign p2_last = p2_ctx.k == LAST_K;
  assign esc_now = p2_esc && !p2_ctx.done;

  always_comb begin
    loop_ctx      = p2_ctx;
    loop_ctx.k    = p2_ctx.k + K_W'(1);
    loop_ctx.cnt  = esc_now ? p2_ctx.k : p2_ctx.cnt;
    loop_ctx.done = p2_ctx.done || p2_esc;
  end

  // Every point makes the full number of passes so results leave in arrival order.
  assign recirc   = p2_valid && !p2_last;
  assign stall    = p2_valid && p2_last && res_valid && !result.ready;
  assign res_load = p2_valid && p2_last && (!res_valid || result.ready);

  assign point.ready = !stall && !recirc;
  assign take        = point.valid && point.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_valid  <= 1'b0;
      p1_valid  <= 1'b0;
      p2_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (!stall) begin
        p0_valid <= recirc || take;
        p1_valid <= p0_valid;
        p2_valid <= p1_valid;
      end
      if (!res_valid || result.ready) begin
        res_valid <= p2_valid && p2_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      if (recirc) begin
        p0_ctx <= loop_ctx;
        p0_zr  <= sat(re_full);
        p0_zi  <= sat(im_full);
      end else begin
        p0_ctx.cr   <= point.data.c_real;
        p0_ctx.ci   <= point.data.c_imag;
        p0_ctx.k    <= K_W'(1);
        p0_ctx.cnt  <= K_W'(MAX_STEPS);
        p0_ctx.done <= 1'b0;
        p0_zr       <= point.data.c_real;
        p0_zi       <= point.data.c_imag;
      end

      p1_ctx <= p0_ctx;
      p1_rr  <= PROD_W'(p0_zr) * PROD_W'(p0_zr);
      p1_ii  <= PROD_W'(p0_zi) * PROD_W'(p0_zi);
      p1_ri  <= PROD_W'(p0_zr) * PROD_W'(p0_zi);

      p2_ctx  <= p1_ctx;
      p2_diff <= p1_rr - p1_ii;
      p2_ri   <= p1_ri;
      p2_esc  <= (sq_sum >> FRAC_BITS) >= ESC_LIMIT;
    end
    if (res_load) begin
      res_count <= COUNT_W'(loop_ctx.cnt);
    end
  end

  assign result.valid             = res_valid;
  assign result.data.escape_count = res_count;

endmodule

`default_nettype wire

FILE: rtl/mec_checker.sv
// Port-level checker for the escape counter, bound to the top level.
`default_nettype none

`include "mandelbrot_escape_counter_top_assert.svh"

module mec_checker
  import mec_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [COUNT_W-1:0] out_count
);

  // Three loop slots plus the output register.
  localparam logic [2:0] CAPACITY = 3'd4;

  logic [2:0] outstanding;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= 3'd0;
    end else begin
      outstanding <= outstanding + 3'(in_acc) - 3'(out_acc);
    end
  end

  `MEC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_count), "result changed while stalled")
  `MEC_ASSERT_NOW(a_no_phantom, out_valid, outstanding != 3'd0, "result without a pending point")
  `MEC_ASSERT_NOW(a_capacity, outstanding == CAPACITY && !out_ready, !in_ready, "point taken while full")
  `MEC_ASSERT_NEXT(a_min_latency, in_acc && outstanding == 3'd0, !out_valid, "result appeared too early")

endmodule

bind mandelbrot_escape_counter_top mec_checker u_mec_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (point.valid),
  .in_ready  (point.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_count (result.data.escape_count)
);

`default_nettype wire

FILE: verif/mandelbrot_escape_counter_top_test.sv
// Testbench for the Mandelbrot escape counter: directed and random points checked in order.
`default_nettype none

module mandelbrot_escape_counter_top_test;
  import mec_pkg::*;

  localparam int ITER_LIMIT = 256;
  localparam int FRAC = 28;
  localparam int ONE = 1 << FRAC;
  localparam int RANDOM_POINTS = 1280;
  localparam int QUIET_TAIL = 100;
  localparam int HOLD_AFTER = 100;
  localparam int HOLD_CYCLES = 4000;
  localparam int DRAIN_CYCLES = 3 * ITER_LIMIT + 50;
  localparam int MAX_REPORTS = 10;
  localparam longint COORD_MAX = 64'sd2147483647;
  localparam longint COORD_MIN = -64'sd2147483648;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mec_stream_if #(.T(point_t)) point_ch ();
  mec_stream_if #(.T(count_t)) result_ch ();

  mandelbrot_escape_counter_top #(
    .MAX_STEPS(ITER_LIMIT),
    .FRAC_BITS(FRAC)
  ) dut (
    .clk(clk),
    .rst(rst),
    .point(point_ch),
    .result(result_ch)
  );

  point_t             pending_points[$];
  logic [COUNT_W-1:0] expected_counts[$];
  int total_points = 0;
  int accepted_points = 0;
  int results_seen = 0;
  int fail_count = 0;
  int cycle_count = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint clamp_coord(longint v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  // Iterates z = z^2 + c in fixed point; products are exact, shifts floor toward minus infinity.
  function automatic logic [COUNT_W-1:0] escape_time(point_t p);
    longint cr, ci, zr, zi, nr, ni;
    longint unsigned mag2;
    logic [COUNT_W-1:0] steps;
    cr = longint'($signed(p.c_real));
    ci = longint'($signed(p.c_imag));
    zr = cr;
    zi = ci;
    steps = COUNT_W'(ITER_LIMIT);
    for (int k = 1; k < ITER_LIMIT; k++) begin
      mag2 = $unsigned(zr * zr) + $unsigned(zi * zi);
      if ((mag2 >> FRAC) >= (64'd4 << FRAC)) begin
        steps = COUNT_W'(k);
        break;
      end
      nr = ((zr * zr - zi * zi) >>> FRAC) + cr;
      ni = ((zr * zi) >>> (FRAC - 1)) + ci;
      zr = clamp_coord(nr);
      zi = clamp_coord(ni);
    end
    return steps;
  endfunction

  function automatic void add_point(int re, int im);
    point_t p;
    p.c_real = re;
    p.c_imag = im;
    pending_points.push_back(p);
  endfunction

  function automatic void report_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("ERROR: %s", msg);
  endfunction

  // Whenever bits 13:12 of the cycle count are both set, neither side starts a new random gap.
  function automatic bit calm_phase();
    return ((cycle_count >> 12) % 4) == 3;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      point_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (point_ch.valid && point_ch.ready) begin
        expected_counts.push_back(escape_time(point_ch.data));
        accepted_points <= accepted_points + 1;
      end
      if (!point_ch.valid || point_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          point_ch.valid <= 1'b0;
        end else if (pending_points.size() == 0) begin
          point_ch.valid <= 1'b0;
        end else if (!calm_phase() && pending_points.size() > QUIET_TAIL &&
                     $urandom_range(7) == 0) begin
          send_gap = $urandom_range(14);
          point_ch.valid <= 1'b0;
        end else begin
          point_ch.valid <= 1'b1;
          point_ch.data <= pending_points.pop_front();
        end
      end
    end
  end

  // The long receiver hold-off lets the loop fill so the point input stalls.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin : result_monitor
    logic [COUNT_W-1:0] want;
    if (rst) begin
      result_ch.ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        results_seen <= results_seen + 1;
        if (expected_counts.size() == 0) begin
          report_failure($sformatf("escape count %0d arrived with no point outstanding",
                                   result_ch.data.escape_count));
        end else begin
          want = expected_counts.pop_front();
          if (result_ch.data.escape_count !== want)
            report_failure($sformatf("result %0d: expected escape count %0d, got %0d",
                                     results_seen, want, result_ch.data.escape_count));
        end
      end
      if (hold_left > 0) begin
        result_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        result_ch.ready <= 1'b0;
      end else if (!calm_phase() && results_seen < total_points - QUIET_TAIL &&
                   $urandom_range(15) == 0) begin
        recv_gap = $urandom_range(14);
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int base_re[8] = '{-201326592, 67108864, -335544320, -26843546,
                       75161928, -475134362, -42949673, 99321119};
    int base_im[8] = '{26843546, 0, 0, 174483046,
                       142270792, 0, 279172874, 26843546};
    int sel, idx, re, im;

    // Origin never escapes, so the count is capped.
    add_point(0, 0);
    add_point(32'h7FFFFFFF, 32'h7FFFFFFF);
    add_point(32'h80000000, 32'h80000000);
    add_point(32'h7FFFFFFF, 32'h80000000);
    add_point(32'h80000000, 32'h7FFFFFFF);
    // Magnitude exactly two escapes at once; one step inside does not.
    add_point(-2 * ONE, 0);
    add_point(2 * ONE - 1, 0);
    add_point(0, 2 * ONE);
    add_point(0, -2 * ONE);
    add_point(-2 * ONE + 1, 0);
    // The cusp converges slowly; just beyond it the escape comes late.
    add_point(ONE / 4, 0);
    add_point(ONE / 4 + (1 << 16), 0);
    add_point(-ONE, 0);
    add_point(0, ONE);
    add_point(-3 * ONE / 4, ONE / 64);
    add_point(-3 * ONE / 4, 0);
    add_point(-ONE, 1);
    add_point(32'h7FFFFFFF, 0);
    add_point(0, 32'h80000000);
    add_point(-1, -1);
    add_point(1, 1);
    add_point(ONE, ONE);

    for (int n = 0; n < RANDOM_POINTS; n++) begin
      sel = $urandom_range(99);
      if (sel < 15) begin
        re = $urandom;
        im = $urandom;
      end else if (sel < 50) begin
        re = int'($urandom_range(805306368)) - 603979776;
        im = int'($urandom_range(805306368)) - 402653184;
      end else if (sel < 85) begin
        // Near the set boundary, where escape counts spread over the whole range.
        idx = $urandom_range(7);
        re = base_re[idx] + ((int'($urandom_range(1 << 22)) - (1 << 21)) >>> $urandom_range(8));
        im = base_im[idx] + ((int'($urandom_range(1 << 22)) - (1 << 21)) >>> $urandom_range(8));
      end else begin
        re = int'($urandom_range(ONE / 2)) - ONE / 4;
        im = int'($urandom_range(ONE / 2)) - ONE / 4;
      end
      add_point(re, im);
    end
    total_points = pending_points.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (accepted_points < total_points) @(posedge clk);
    while (expected_counts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #72000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+rtl
rtl/mec_pkg.sv
rtl/mec_stream_if.sv
rtl/mandelbrot_escape_counter_top.sv
rtl/mec_checker.sv
verif/mandelbrot_escape_counter_top_test.sv
